>>> sv/sst_pkg.sv
// ---------------------------------------------------------------------------
// sst_pkg
// Types, constants and scanning functions shared by the tokenizer modules.
// ---------------------------------------------------------------------------
package sst_pkg;

    // Default width of the internal byte position counters.
    localparam int POS_WIDTH_DEF = 16;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Most results that one input item can cause.
    localparam int MAX_RES = 4;

    // Scanner modes; operator modes follow from MODE_OPS upwards.
    localparam logic [4:0] MODE_START   = 5'd0;
    localparam logic [4:0] MODE_COMMENT = 5'd1;
    localparam logic [4:0] MODE_IDENT   = 5'd2;
    localparam logic [4:0] MODE_INT     = 5'd3;
    localparam logic [4:0] MODE_INTDOT  = 5'd4;
    localparam logic [4:0] MODE_FLOAT   = 5'd5;
    localparam logic [4:0] MODE_DOT     = 5'd6;
    localparam logic [4:0] MODE_STRING  = 5'd7;
    localparam logic [4:0] MODE_CHOPEN  = 5'd8;
    localparam logic [4:0] MODE_CHVAL   = 5'd9;
    localparam logic [4:0] MODE_DONE    = 5'd10;
    localparam logic [4:0] MODE_OPS     = 5'd11;
    localparam logic [4:0] MODE_OPS_END = 5'd20;

    // Token kinds with a fixed role.
    localparam logic [5:0] KIND_NONE   = 6'd0;
    localparam logic [5:0] KIND_INT    = 6'd13;
    localparam logic [5:0] KIND_FLOAT  = 6'd14;
    localparam logic [5:0] KIND_STRING = 6'd15;
    localparam logic [5:0] KIND_CHAR   = 6'd16;
    localparam logic [5:0] KIND_IDENT  = 6'd17;
    localparam logic [5:0] KIND_EOF    = 6'd18;
    localparam logic [5:0] KIND_DOT    = 6'd28;
    localparam logic [5:0] KIND_RANGE  = 6'd29;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_STRING     = 2'd2;
    localparam logic [1:0] ERR_CHAR       = 2'd3;

    // No operator row matches.
    localparam logic [3:0] OP_NONE = 4'd15;

    typedef struct packed {
        logic [4:0]       mode;
        logic [31:0]      tstart;
        logic [31:0]      off;
        logic [15:0]      line;
        logic [5:0][7:0]  prefix;
        logic [2:0]       wlen;
        logic [7:0]       lchar;
    } sst_state_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] spos;
        logic [15:0] epos;
        logic [15:0] line;
        logic [7:0]  ch;
    } sst_res_t;

    typedef struct packed {
        logic [2:0]          cnt;
        sst_res_t [MAX_RES-1:0] res;
    } sst_bundle_t;

    typedef struct packed {
        sst_state_t          st;
        logic [2:0]          cnt;
        sst_res_t [MAX_RES-1:0] res;
    } sst_feed_t;

    // Character classes.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // Keyword text, right aligned, first character highest.
    function automatic logic [47:0] kw_text(input logic [3:0] i);
        case (i)
            4'd0:    return 48'("func");
            4'd1:    return 48'("let");
            4'd2:    return 48'("const");
            4'd3:    return 48'("if");
            4'd4:    return 48'("else");
            4'd5:    return 48'("while");
            4'd6:    return 48'("for");
            4'd7:    return 48'("in");
            4'd8:    return 48'("return");
            4'd9:    return 48'("struct");
            4'd10:   return 48'("true");
            4'd11:   return 48'("false");
            4'd12:   return 48'("null");
            default: return 48'd0;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] i);
        case (i)
            4'd0, 4'd4, 4'd10, 4'd12: return 3'd4;
            4'd1, 4'd6:               return 3'd3;
            4'd2, 4'd5, 4'd11:        return 3'd5;
            4'd3, 4'd7:               return 3'd2;
            4'd8, 4'd9:               return 3'd6;
            default:                  return 3'd7;
        endcase
    endfunction

    // Kind of a finished word: the first keyword that matches, else identifier.
    function automatic logic [5:0] word_kind(input logic [5:0][7:0] prefix,
                                             input logic [2:0] wlen);
        logic [5:0]  kind;
        logic [47:0] txt;
        logic [2:0]  len;
        logic        hit;
        kind = KIND_IDENT;
        for (int i = 12; i >= 0; i--)
        begin
            txt = kw_text(4'(i));
            len = kw_len(4'(i));
            hit = (wlen == len);
            for (int j = 0; j < 6; j++)
            begin
                if (j < int'(len))
                begin
                    if (prefix[j] != txt[(int'(len) - 1 - j) * 8 +: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit)
            begin
                kind = 6'(i);
            end
        end
        return kind;
    endfunction

    // Operators that may take a second character.
    function automatic logic [7:0] op_first(input logic [3:0] i);
        case (i)
            4'd0:    return "+";
            4'd1:    return "-";
            4'd2:    return "*";
            4'd3:    return "/";
            4'd4:    return "=";
            4'd5:    return "!";
            4'd6:    return "<";
            4'd7:    return ">";
            4'd8:    return "&";
            4'd9:    return "|";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [5:0] op_single(input logic [3:0] i);
        case (i)
            4'd0:    return 6'd30;
            4'd1:    return 6'd32;
            4'd2:    return 6'd35;
            4'd3:    return 6'd37;
            4'd4:    return 6'd39;
            4'd5:    return 6'd41;
            4'd6:    return 6'd43;
            4'd7:    return 6'd46;
            4'd8:    return 6'd49;
            4'd9:    return 6'd51;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] op_c1(input logic [3:0] i);
        case (i)
            4'd1:       return ">";
            4'd6:       return "<";
            4'd7:       return ">";
            4'd8:       return "&";
            4'd9:       return "|";
            4'd0, 4'd2, 4'd3, 4'd4, 4'd5: return "=";
            default:    return 8'd0;
        endcase
    endfunction

    function automatic logic [5:0] op_k1(input logic [3:0] i);
        case (i)
            4'd0:    return 6'd31;
            4'd1:    return 6'd34;
            4'd2:    return 6'd36;
            4'd3:    return 6'd38;
            4'd4:    return 6'd40;
            4'd5:    return 6'd42;
            4'd6:    return 6'd45;
            4'd7:    return 6'd48;
            4'd8:    return 6'd50;
            4'd9:    return 6'd52;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] op_c2(input logic [3:0] i);
        case (i)
            4'd1, 4'd6, 4'd7: return "=";
            default:          return 8'd0;
        endcase
    endfunction

    function automatic logic [5:0] op_k2(input logic [3:0] i);
        case (i)
            4'd1:    return 6'd33;
            4'd6:    return 6'd44;
            4'd7:    return 6'd47;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [3:0] op_index(input logic [7:0] c);
        logic [3:0] idx;
        idx = OP_NONE;
        for (int i = 9; i >= 0; i--)
        begin
            if (op_first(4'(i)) == c)
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    // One-character tokens that never take a second character.
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "(":     return 6'd19;
            ")":     return 6'd20;
            "{":     return 6'd21;
            "}":     return 6'd22;
            "[":     return 6'd23;
            "]":     return 6'd24;
            ",":     return 6'd25;
            ":":     return 6'd26;
            ";":     return 6'd27;
            "^":     return 6'd53;
            "~":     return 6'd54;
            "%":     return 6'd55;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic sst_res_t mk_res(input logic [5:0] kind, input logic [1:0] err,
                                        input logic [31:0] spos, input logic [31:0] epos,
                                        input logic [15:0] line, input logic [7:0] ch);
        sst_res_t r;
        r.kind = kind;
        r.err  = err;
        r.spos = spos[15:0];
        r.epos = epos[15:0];
        r.line = line;
        r.ch   = ch;
        return r;
    endfunction

    // Consume one byte (zero is the end of the source). A pending token may
    // be resolved first, so the mode can be revisited a few times.
    function automatic sst_feed_t sst_feed(input sst_state_t s, input logic [7:0] c);
        sst_feed_t  f;
        logic       go;
        logic [31:0] cur;
        logic [31:0] prev;
        logic [31:0] prev2;
        logic [3:0] oi;
        logic [3:0] ri;
        f.st  = s;
        f.cnt = 3'd0;
        f.res = '0;
        go    = 1'b1;
        cur   = s.off;
        prev  = (cur != 32'd0) ? cur - 32'd1 : 32'd0;
        prev2 = (prev != 32'd0) ? prev - 32'd1 : 32'd0;
        oi    = op_index(c);
        for (int it = 0; it < 4; it++)
        begin
            if (go)
            begin
                go = 1'b0;
                ri = 4'(f.st.mode - MODE_OPS);
                case (f.st.mode)
                    MODE_START:
                    begin
                        if (c == 8'd0)
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_EOF, ERR_NONE, cur, cur, s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_DONE;
                        end
                        else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)
                        begin
                            f.st.mode = MODE_START;
                        end
                        else
                        begin
                            f.st.tstart = cur;
                            if (is_alpha(c) || c == "_")
                            begin
                                f.st.prefix[0] = c;
                                f.st.wlen = 3'd1;
                                f.st.mode = MODE_IDENT;
                            end
                            else if (is_digit(c))
                            begin
                                f.st.mode = MODE_INT;
                            end
                            else if (c == ".")
                            begin
                                f.st.mode = MODE_DOT;
                            end
                            else if (c == "\"")
                            begin
                                f.st.mode = MODE_STRING;
                            end
                            else if (c == "'")
                            begin
                                f.st.mode = MODE_CHOPEN;
                            end
                            else if (oi != OP_NONE)
                            begin
                                f.st.mode = MODE_OPS + 5'(oi);
                            end
                            else if (single_kind(c) != KIND_NONE)
                            begin
                                f.res[f.cnt[1:0]] = mk_res(single_kind(c), ERR_NONE, cur, cur,
                                                           s.line, 8'd0);
                                f.cnt = f.cnt + 3'd1;
                            end
                            else
                            begin
                                f.res[f.cnt[1:0]] = mk_res(KIND_NONE, ERR_UNEXPECTED, cur, cur,
                                                           s.line, 8'd0);
                                f.cnt = f.cnt + 3'd1;
                                f.st.mode = MODE_DONE;
                            end
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (c == 8'd0)
                        begin
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                        else if (c == 8'h0A)
                        begin
                            f.st.mode = MODE_START;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (c != 8'd0 && is_word(c))
                        begin
                            if (f.st.wlen < 3'd6)
                            begin
                                f.st.prefix[f.st.wlen] = c;
                            end
                            if (f.st.wlen < 3'd7)
                            begin
                                f.st.wlen = f.st.wlen + 3'd1;
                            end
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res(word_kind(f.st.prefix, f.st.wlen),
                                                       ERR_NONE, f.st.tstart, prev,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                    end
                    MODE_INT, MODE_FLOAT:
                    begin
                        if (is_digit(c))
                        begin
                            f.st.mode = f.st.mode;
                        end
                        else if (c == "." && f.st.mode == MODE_INT)
                        begin
                            f.st.mode = MODE_INTDOT;
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res((f.st.mode == MODE_INT) ? KIND_INT
                                                       : KIND_FLOAT, ERR_NONE, f.st.tstart,
                                                       prev, s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                    end
                    MODE_INTDOT:
                    begin
                        if (is_digit(c))
                        begin
                            f.st.mode = MODE_FLOAT;
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_INT, ERR_NONE, f.st.tstart, prev2,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.tstart = prev;
                            f.st.mode = MODE_DOT;
                            go = 1'b1;
                        end
                    end
                    MODE_DOT:
                    begin
                        if (c == ".")
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_RANGE, ERR_NONE, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_DOT, ERR_NONE, f.st.tstart,
                                                       f.st.tstart, s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (c == 8'd0)
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_NONE, ERR_STRING, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_DONE;
                        end
                        else if (c == "\"")
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_STRING, ERR_NONE, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                        end
                    end
                    MODE_CHOPEN:
                    begin
                        if (c == 8'd0)
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_NONE, ERR_CHAR, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_DONE;
                        end
                        else
                        begin
                            f.st.lchar = c;
                            f.st.mode = MODE_CHVAL;
                        end
                    end
                    MODE_CHVAL:
                    begin
                        if (c == "'")
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_CHAR, ERR_NONE, f.st.tstart, cur,
                                                       s.line, f.st.lchar);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res(KIND_NONE, ERR_CHAR, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_DONE;
                        end
                    end
                    MODE_DONE:
                    begin
                        f.st.mode = MODE_DONE;
                    end
                    default:
                    begin
                        if (f.st.mode > MODE_OPS_END)
                        begin
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                        else if (op_first(ri) == "/" && c == "/")
                        begin
                            f.st.mode = MODE_COMMENT;
                        end
                        else if (c != 8'd0 && c == op_c1(ri))
                        begin
                            f.res[f.cnt[1:0]] = mk_res(op_k1(ri), ERR_NONE, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                        end
                        else if (c != 8'd0 && c == op_c2(ri))
                        begin
                            f.res[f.cnt[1:0]] = mk_res(op_k2(ri), ERR_NONE, f.st.tstart, cur,
                                                       s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                        end
                        else
                        begin
                            f.res[f.cnt[1:0]] = mk_res(op_single(ri), ERR_NONE, f.st.tstart,
                                                       f.st.tstart, s.line, 8'd0);
                            f.cnt = f.cnt + 3'd1;
                            f.st.mode = MODE_START;
                            go = 1'b1;
                        end
                    end
                endcase
            end
        end
        return f;
    endfunction

endpackage

>>> sv/sst_if.sv
// ---------------------------------------------------------------------------
// sst_in_if / sst_out_if
// Ready/valid channels for source bytes and for tokens.
// ---------------------------------------------------------------------------
interface sst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface sst_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line_no;
    logic [7:0]  char_value;
    logic        run_last;

    modport source (output valid, output token_kind, output error_code, output start_pos,
                    output end_pos, output line_no, output char_value, output run_last,
                    input ready);
    modport sink   (input valid, input token_kind, input error_code, input start_pos,
                    input end_pos, input line_no, input char_value, input run_last,
                    output ready);
endinterface

>>> sv/sst_front.sv
// ---------------------------------------------------------------------------
// sst_front
// Scanner front end: takes one byte a cycle while the queue has room, advances the
// scanner state and hands the tokens that the byte completes to the queue as one bundle.
// ---------------------------------------------------------------------------
module sst_front
    import sst_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sst_in_if.sink      char_ch,
    output logic        push_valid,
    input  logic        push_ready,
    output sst_bundle_t push_bundle
);

    localparam logic [31:0] POS_MAX = 32'({POS_WIDTH{1'b1}});

    logic [4:0]           mode_reg,   mode_next;
    logic [POS_WIDTH-1:0] tstart_reg, tstart_next;
    logic [POS_WIDTH-1:0] off_reg,    off_next;
    logic [15:0]          line_reg,   line_next;
    logic [5:0][7:0]      prefix_reg, prefix_next;
    logic [2:0]           wlen_reg,   wlen_next;
    logic [7:0]           lchar_reg,  lchar_next;

    sst_state_t st0;
    sst_state_t st1;
    sst_feed_t  f1;
    sst_feed_t  f2;
    logic       take;
    logic       has_char;
    logic [3:0] total;

    // Ready follows the queue alone.
    assign char_ch.ready = push_ready;
    assign take          = char_ch.valid && push_ready;
    assign has_char      = (char_ch.char_in != 8'd0);

    // Feed the byte, then a closing zero byte where the item ends the source.
    always_comb
    begin
        st0.mode   = mode_reg;
        st0.tstart = 32'(tstart_reg);
        st0.off    = 32'(off_reg);
        st0.line   = line_reg;
        st0.prefix = prefix_reg;
        st0.wlen   = wlen_reg;
        st0.lchar  = lchar_reg;
        f1 = sst_feed(st0, char_ch.char_in);
        st1 = f1.st;
        if (has_char)
        begin
            if (char_ch.char_in == 8'h0A && st1.line != 16'hFFFF)
            begin
                st1.line = st1.line + 16'd1;
            end
            if (st1.off < POS_MAX)
            begin
                st1.off = st1.off + 32'd1;
            end
        end
        f2 = sst_feed(st1, 8'd0);
        if (!(has_char && char_ch.end_of_input))
        begin
            f2.cnt = 3'd0;
            f2.st  = st1;
        end
    end

    // Merge both result lists, keeping at most four.
    always_comb
    begin
        total = {1'b0, f1.cnt} + {1'b0, f2.cnt};
        push_bundle.cnt = (total > 4'(MAX_RES)) ? 3'(MAX_RES) : total[2:0];
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (3'(k) < f1.cnt)
            begin
                push_bundle.res[k] = f1.res[k];
            end
            else
            begin
                push_bundle.res[k] = f2.res[2'(3'(k) - f1.cnt)];
            end
        end
        push_valid = char_ch.valid && (push_bundle.cnt != 3'd0);
    end

    // Next state; the end of the source returns all but the word prefix to reset.
    always_comb
    begin
        mode_next   = f2.st.mode;
        tstart_next = f2.st.tstart[POS_WIDTH-1:0];
        off_next    = f2.st.off[POS_WIDTH-1:0];
        line_next   = f2.st.line;
        prefix_next = f2.st.prefix;
        wlen_next   = f2.st.wlen;
        lchar_next  = f2.st.lchar;
        if (char_ch.end_of_input)
        begin
            mode_next   = MODE_START;
            tstart_next = '0;
            off_next    = '0;
            line_next   = 16'd1;
            wlen_next   = 3'd0;
            lchar_next  = 8'd0;
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            tstart_reg <= '0;
            off_reg    <= '0;
            line_reg   <= 16'd1;
            wlen_reg   <= 3'd0;
            lchar_reg  <= 8'd0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            off_reg    <= off_next;
            line_reg   <= line_next;
            wlen_reg   <= wlen_next;
            lchar_reg  <= lchar_next;
        end
    end

    // Word prefix bytes are payload and need no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

>>> sv/sst_queue.sv
// ---------------------------------------------------------------------------
// sst_queue
// Short queue of token bundles between the front and the back end.
// ---------------------------------------------------------------------------
module sst_queue
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  sst_bundle_t push_bundle,
    output logic        pop_valid,
    input  logic        pop_ready,
    output sst_bundle_t pop_bundle
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sst_bundle_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_bundle = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_bundle;
        end
    end

endmodule

>>> sv/sst_back.sv
// ---------------------------------------------------------------------------
// sst_back
// Back end: holds one bundle and presents its tokens one item a cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module sst_back
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  sst_bundle_t pop_bundle,
    sst_out_if.source   token_ch
);

    sst_bundle_t head_reg;
    logic        valid_reg;
    logic [1:0]  idx_reg;
    logic        is_last;
    logic        fire;
    sst_res_t    cur;

    assign cur     = head_reg.res[idx_reg];
    assign is_last = ({1'b0, idx_reg} + 3'd1 == head_reg.cnt);
    assign fire    = valid_reg && token_ch.ready;

    // Take the next bundle once the current one is empty or finishing.
    assign pop_ready = !valid_reg || (fire && is_last);

    assign token_ch.valid      = valid_reg;
    assign token_ch.token_kind = cur.kind;
    assign token_ch.error_code = cur.err;
    assign token_ch.start_pos  = cur.spos;
    assign token_ch.end_pos    = cur.epos;
    assign token_ch.line_no    = cur.line;
    assign token_ch.char_value = cur.ch;
    assign token_ch.run_last   = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (pop_ready)
        begin
            valid_reg <= pop_valid;
            idx_reg   <= 2'd0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            head_reg <= pop_bundle;
        end
    end

endmodule

>>> sv/script_source_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// script_source_tokenizer_unit
// Streaming tokenizer: source bytes in, tokens with positions and line out.
// ---------------------------------------------------------------------------
//  Channel   Direction  Item
//  char_ch   in         char_in, end_of_input (one source byte)
//  token_ch  out        token_kind, error_code, start_pos, end_pos, line_no,
//                       char_value, run_last (one token)
//
// A byte is taken every cycle while the bundle queue has room; the scanner
// step for the byte and an optional closing step finish in that cycle.
// The tokens of a byte pass through a queue entry and the back end's head
// register before they are offered, then leave one token a cycle while the
// receiver is ready.
// Reset clears the scanner state and empties the queue and output stage.
// A stalled output fills the two-entry queue, after which char_ch stalls.
// ---------------------------------------------------------------------------
module script_source_tokenizer_unit
    import sst_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    sst_in_if.sink     char_ch,
    sst_out_if.source  token_ch
);

    logic        push_valid;
    logic        push_ready;
    sst_bundle_t push_bundle;
    logic        pop_valid;
    logic        pop_ready;
    sst_bundle_t pop_bundle;

    sst_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_ch     (char_ch),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_bundle (push_bundle)
    );

    sst_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_bundle (push_bundle),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_bundle  (pop_bundle)
    );

    sst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_bundle (pop_bundle),
        .token_ch   (token_ch)
    );

endmodule

>>> tb/script_source_tokenizer_unit_tb.sv
// ---------------------------------------------------------------------------
// script_source_tokenizer_unit_tb
// Self-checking bench for the streaming tokenizer. Source bytes are driven
// through the input channel, an independent scanner model predicts the tokens
// of each accepted item, and a scoreboard compares every token that leaves
// the block, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_source_tokenizer_unit_tb
    import sst_pkg::*;
();

    localparam int  HALF_PERIOD = 4;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [5:0] KIND_FUNC = 6'd0;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] spos;
        logic [15:0] epos;
        logic [15:0] line;
        logic [7:0]  ch;
        logic        last;
    } token_t;

    // Scoreboard: holds the tokens still to come and checks each arrival.
    class token_scoreboard;
        token_t pending[$];
        int     errors;

        function void note_token(token_t t);
            pending.push_back(t);
        endfunction

        // Print one line for a mismatch and count it.
        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_token(token_t got);
            token_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("token kind %0d arrived with none expected", got.kind));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                report($sformatf({"token got k%0d e%0d s%0d e%0d l%0d c%0d r%0d,",
                                  " want k%0d e%0d s%0d e%0d l%0d c%0d r%0d"},
                                 got.kind, got.err, got.spos, got.epos, got.line, got.ch,
                                 got.last, want.kind, want.err, want.spos, want.epos,
                                 want.line, want.ch, want.last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   hold_cycles;
    bit   quiet_phase;

    sst_in_if  char_ch ();
    sst_out_if token_ch ();

    token_scoreboard board;

    script_source_tokenizer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_ch),
        .token_ch (token_ch)
    );

    // Scanner model state.
    logic [4:0]  scan_mode;
    logic [15:0] tok_start;
    logic [15:0] offset;
    logic [15:0] line_cnt;
    logic [7:0]  word_buf [6];
    int          word_len;
    logic [7:0]  held_char;
    token_t      step_tokens[$];

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [15:0] down_one(logic [15:0] v);
        return (v != 0) ? v - 16'd1 : 16'd0;
    endfunction

    task automatic reset_scanner();
        scan_mode = MODE_START;
        tok_start = 0;
        offset    = 0;
        line_cnt  = 1;
        word_len  = 0;
        held_char = 0;
    endtask

    task automatic add_token(logic [5:0] k, logic [1:0] e, logic [15:0] s, logic [15:0] p,
                             logic [7:0] ch);
        token_t t;
        t = '{k, e, s, p, line_cnt, ch, 1'b0};
        if (step_tokens.size() < MAX_RES)
            step_tokens.push_back(t);
    endtask

    function automatic logic [5:0] classify_word();
        string words[13] = '{"func", "let", "const", "if", "else", "while", "for", "in",
                             "return", "struct", "true", "false", "null"};
        bit    same;
        for (int i = 0; i < 13; i++)
        begin
            if (word_len == words[i].len())
            begin
                same = 1;
                for (int j = 0; j < word_len; j++)
                    if (word_buf[j] != words[i][j])
                        same = 0;
                if (same)
                    return KIND_FUNC + 6'(i);
            end
        end
        return KIND_IDENT;
    endfunction

    // Operator rows by first char; single kinds, second chars and their kinds are in scan_byte.
    function automatic int op_row(logic [7:0] c);
        string firsts = "+-*/=!<>&|";
        for (int i = 0; i < 10; i++)
            if (firsts[i] == c)
                return i;
        return -1;
    endfunction

    function automatic logic [5:0] lone_kind(logic [7:0] c);
        case (c)
            "(": return 6'd19;  ")": return 6'd20;  "{": return 6'd21;
            "}": return 6'd22;  "[": return 6'd23;  "]": return 6'd24;
            ",": return 6'd25;  ":": return 6'd26;  ";": return 6'd27;
            "^": return 6'd53;  "~": return 6'd54;  "%": return 6'd55;
            default: return KIND_NONE;
        endcase
    endfunction

    // Advance the scanner by one byte; zero closes the source.
    task automatic scan_byte(logic [7:0] c);
        logic [15:0] cur;
        logic [15:0] prv;
        bit          again;
        int          row;
        string       sec1;
        logic [7:0]  sec2[10];
        logic [5:0]  single_k[10];
        logic [5:0]  k1[10];
        logic [5:0]  k2[10];
        cur = offset;
        prv = down_one(cur);
        sec1 = "=>==!=<>&|";
        sec2 = '{8'd0, "=", 8'd0, 8'd0, 8'd0, 8'd0, "=", "=", 8'd0, 8'd0};
        single_k = '{30, 32, 35, 37, 39, 41, 43, 46, 49, 51};
        k1 = '{31, 34, 36, 38, 40, 42, 45, 48, 50, 52};
        k2 = '{0, 33, 0, 0, 0, 0, 44, 47, 0, 0};
        sec1[4] = "=";
        sec1[5] = "=";
        sec1[2] = "=";
        sec1[3] = "=";
        sec1[6] = "<";
        sec1[7] = ">";
        again = 1;
        while (again)
        begin
            again = 0;
            if (scan_mode == MODE_DONE)
                return;
            case (scan_mode)
                MODE_START:
                begin
                    if (c == 0)
                    begin
                        add_token(KIND_EOF, ERR_NONE, cur, cur, 0);
                        scan_mode = MODE_DONE;
                    end
                    else if (!(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A))
                    begin
                        tok_start = cur;
                        row = op_row(c);
                        if (is_letter(c) || c == "_")
                        begin
                            word_buf[0] = c;
                            word_len = 1;
                            scan_mode = MODE_IDENT;
                        end
                        else if (is_num(c))
                            scan_mode = MODE_INT;
                        else if (c == ".")
                            scan_mode = MODE_DOT;
                        else if (c == "\"")
                            scan_mode = MODE_STRING;
                        else if (c == "'")
                            scan_mode = MODE_CHOPEN;
                        else if (row >= 0)
                            scan_mode = MODE_OPS + 5'(row);
                        else if (lone_kind(c) != KIND_NONE)
                            add_token(lone_kind(c), ERR_NONE, cur, cur, 0);
                        else
                        begin
                            add_token(KIND_NONE, ERR_UNEXPECTED, cur, cur, 0);
                            scan_mode = MODE_DONE;
                        end
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == 0)
                    begin
                        scan_mode = MODE_START;
                        again = 1;
                    end
                    else if (c == 8'h0A)
                        scan_mode = MODE_START;
                end
                MODE_IDENT:
                begin
                    if (c != 0 && (is_letter(c) || is_num(c) || c == "_"))
                    begin
                        if (word_len < 6)
                            word_buf[word_len] = c;
                        if (word_len < 7)
                            word_len++;
                    end
                    else
                    begin
                        add_token(classify_word(), ERR_NONE, tok_start, prv, 0);
                        scan_mode = MODE_START;
                        again = 1;
                    end
                end
                MODE_INT:
                begin
                    if (c == ".")
                        scan_mode = MODE_INTDOT;
                    else if (!is_num(c))
                    begin
                        add_token(KIND_INT, ERR_NONE, tok_start, prv, 0);
                        scan_mode = MODE_START;
                        again = 1;
                    end
                end
                MODE_INTDOT:
                begin
                    if (is_num(c))
                        scan_mode = MODE_FLOAT;
                    else
                    begin
                        add_token(KIND_INT, ERR_NONE, tok_start, down_one(prv), 0);
                        tok_start = prv;
                        scan_mode = MODE_DOT;
                        again = 1;
                    end
                end
                MODE_FLOAT:
                begin
                    if (!is_num(c))
                    begin
                        add_token(KIND_FLOAT, ERR_NONE, tok_start, prv, 0);
                        scan_mode = MODE_START;
                        again = 1;
                    end
                end
                MODE_DOT:
                begin
                    if (c == ".")
                    begin
                        add_token(KIND_RANGE, ERR_NONE, tok_start, cur, 0);
                        scan_mode = MODE_START;
                    end
                    else
                    begin
                        add_token(KIND_DOT, ERR_NONE, tok_start, tok_start, 0);
                        scan_mode = MODE_START;
                        again = 1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == 0)
                    begin
                        add_token(KIND_NONE, ERR_STRING, tok_start, cur, 0);
                        scan_mode = MODE_DONE;
                    end
                    else if (c == "\"")
                    begin
                        add_token(KIND_STRING, ERR_NONE, tok_start, cur, 0);
                        scan_mode = MODE_START;
                    end
                end
                MODE_CHOPEN:
                begin
                    if (c == 0)
                    begin
                        add_token(KIND_NONE, ERR_CHAR, tok_start, cur, 0);
                        scan_mode = MODE_DONE;
                    end
                    else
                    begin
                        held_char = c;
                        scan_mode = MODE_CHVAL;
                    end
                end
                MODE_CHVAL:
                begin
                    if (c == "'")
                    begin
                        add_token(KIND_CHAR, ERR_NONE, tok_start, cur, held_char);
                        scan_mode = MODE_START;
                    end
                    else
                    begin
                        add_token(KIND_NONE, ERR_CHAR, tok_start, cur, 0);
                        scan_mode = MODE_DONE;
                    end
                end
                default:
                begin
                    row = int'(scan_mode - MODE_OPS);
                    if (row == 3 && c == "/")
                        scan_mode = MODE_COMMENT;
                    else if (c != 0 && c == sec1[row])
                    begin
                        add_token(k1[row], ERR_NONE, tok_start, cur, 0);
                        scan_mode = MODE_START;
                    end
                    else if (c != 0 && c == sec2[row])
                    begin
                        add_token(k2[row], ERR_NONE, tok_start, cur, 0);
                        scan_mode = MODE_START;
                    end
                    else
                    begin
                        add_token(single_k[row], ERR_NONE, tok_start, tok_start, 0);
                        scan_mode = MODE_START;
                        again = 1;
                    end
                end
            endcase
        end
    endtask

    // Predict the tokens that one accepted byte causes.
    task automatic predict_item(logic [7:0] c, logic eoi);
        step_tokens.delete();
        if (c == 0)
            scan_byte(0);
        else
        begin
            scan_byte(c);
            if (c == 8'h0A && line_cnt != 16'hFFFF)
                line_cnt++;
            if (offset != 16'hFFFF)
                offset++;
            if (eoi)
                scan_byte(0);
        end
        if (eoi)
            reset_scanner();
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            board.note_token(step_tokens[i]);
    endtask

    // Clock and run limit.
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check each token at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && token_ch.valid && token_ch.ready)
            board.check_token('{token_ch.token_kind, token_ch.error_code, token_ch.start_pos,
                                token_ch.end_pos, token_ch.line_no, token_ch.char_value,
                                token_ch.run_last});
    end

    // Receiver: random stall bursts, a long hold when asked, none at the end.
    initial
    begin
        token_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                token_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                token_ch.ready <= 1'b0;
                hold_cycles = $urandom_range(0, 14);
            end
            else
                token_ch.ready <= 1'b1;
        end
    end

    // Offer one byte and wait until it is taken.
    task automatic send_byte(logic [7:0] c, logic eoi);
        int gap;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid        <= 1'b1;
        char_ch.char_in      <= c;
        char_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!(char_ch.valid && char_ch.ready));
        predict_item(c, eoi);
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    task automatic drain_tokens();
        char_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random source: mostly plausible program text, some noise.
    task automatic send_random_source(int budget, output int used);
        string pieces[] = '{"func ", "let ", "const", "if(", "else{", "while ", "for ", "in ",
                            "return;", "struct ", "true,", "false:", "null]", "abcdefghij ",
                            "x_1 ", "12 ", "3.25 ", "7..9 ", "4.x ", ".5 ", "\"hi\" ", "'q' ",
                            "'ab", "+= ", "-> ", "-= ", "*=", "/=", "== ", "!= ", "<<", "<=",
                            ">>", ">=", "&&", "||", "^~%", "// note\n", "\n", "\t\r", "[]",
                            "a.b", "- ", "< ", "> ", "& ", "| ", "! ", "= ", "/ "};
        string text;
        int    n;
        text = "";
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                text = {text, string'(8'($urandom_range(1, 255)))};
            else
                text = {text, pieces[$urandom_range(0, pieces.size() - 1)]};
        end
        if (text.len() > budget && budget > 0)
            text = text.substr(0, budget - 1);
        used = text.len();
        if ($urandom_range(0, 5) == 0)
        begin
            send_text(text, 0);
            send_byte(0, 0);
            send_byte(8'($urandom), 1);
            used += 2;
        end
        else
            send_text(text, 1);
    endtask

    initial
    begin
        int sent;
        int used;
        board = new();
        cycle_count = 0;
        hold_cycles = 0;
        quiet_phase = 0;
        reset_scanner();
        char_ch.valid = 1'b0;
        char_ch.char_in = 8'd0;
        char_ch.end_of_input = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sources: keywords, numbers, dots, literals, operators, errors.
        send_text("return struct\n1.5 2..", 0);
        send_text("3.x 'z' -> <= >>= // c\n", 1);
        send_text("\"open", 1);
        send_byte(8'hFF, 1);
        send_text("'ab'", 1);
        send_byte(8'h80, 0);
        send_byte(8'h00, 0);
        send_byte(8'h7F, 1);
        drain_tokens();

        // Long receiver hold while bytes keep coming.
        hold_cycles = 200;
        send_text("(a)[b]{c};,:+-*", 1);
        drain_tokens();

        sent = 72;
        while (sent < 310)
        begin
            if (sent > 260)
                quiet_phase = 1;
            send_random_source(310 - sent, used);
            sent += used + 1;
        end
        drain_tokens();
        repeat (20) @(negedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
